@@ rtl/pes_hp_pkg.sv @@
`timescale 1ns / 1ps
// types, codes and field helpers for the pes header parser
package pes_hp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 3;
    localparam int STAMP_W   = 33;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PREFIX,
        PH_HEADER,
        PH_PAYLOAD,
        PH_PADDING,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_IDLE    = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_HDR_END = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_PADDING = 3'd4,
        KIND_ERROR   = 3'd5
    } kind_t;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_START_CODE = 3'd1;
    localparam logic [2:0] ERR_MARKER     = 3'd2;
    localparam logic [2:0] ERR_PTS_PREFIX = 3'd3;
    localparam logic [2:0] ERR_DTS_PREFIX = 3'd4;
    localparam logic [2:0] ERR_HDR_SHORT  = 3'd5;

    localparam logic [7:0] SID_PADDING = 8'hBE;

    localparam logic [1:0] MARKER_BITS     = 2'b10;
    localparam logic [3:0] PFX_PTS_ONLY    = 4'h2;
    localparam logic [3:0] PFX_PTS_WITH_DTS = 4'h3;
    localparam logic [3:0] PFX_DTS         = 4'h1;

    localparam logic [3:0] STAMP_BYTES = 4'd5;
    localparam logic [3:0] ESCR_BYTES  = 4'd6;

    // true unless the id is one of those that carry no optional header
    function automatic logic has_header(input logic [7:0] sid);
        logic none;
        none = (sid == 8'hBC) || (sid == 8'hBE) || (sid == 8'hBF) || (sid == 8'hF0) ||
               (sid == 8'hF1) || (sid == 8'hF2) || (sid == 8'hF8) || (sid == 8'hFF);
        return !none;
    endfunction

    // pts / dts: 3 + 15 + 15 bits spread over five bytes with marker bits
    function automatic logic [STAMP_W-1:0] stamp_update(
        input logic [STAMP_W-1:0] old,
        input logic [2:0]         j,
        input logic [7:0]         b
    );
        logic [STAMP_W-1:0] v;
        v = old;
        case (j)
            3'd0:    v = {b[3:1], 30'd0};
            3'd1:    v[29:22] = b;
            3'd2:    v[21:15] = b[7:1];
            3'd3:    v[14:7] = b;
            default: v[6:0] = b[7:1];
        endcase
        return v;
    endfunction

    // escr base: six bytes, only the first five hold base bits
    function automatic logic [STAMP_W-1:0] escr_update(
        input logic [STAMP_W-1:0] old,
        input logic [2:0]         j,
        input logic [7:0]         b
    );
        logic [STAMP_W-1:0] v;
        v = old;
        case (j)
            3'd0: v = {b[5:3], b[1:0], 28'd0};
            3'd1: v[27:20] = b;
            3'd2: begin
                v[19:15] = b[7:3];
                v[14:13] = b[1:0];
            end
            3'd3:    v[12:5] = b;
            3'd4:    v[4:0] = b[7:3];
            default: v = old;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/pes_header_parser_core.sv @@
`timescale 1ns / 1ps
// pes header parser: byte classification and header field capture
// the result is registered: it appears in the cycle after its input byte is taken
// throughput: one byte per cycle unless s_tready drops; the whole parse step is one
//   combinational pass from the parser state and the byte into the result register
// s_tready drops only while a result waits and the sink is not taking it
// reset (aresetn low, synchronous): parser idle, all captured fields zero,
//   check_markers 1, no result pending
module pes_header_parser_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pes_hp_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic [pes_hp_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] packet_start
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] byte_out, [15:8] stream_ident, [31:16] length_field,
    // [64:32] pts_value, [65] pts_present, [98:66] dts_value, [99] dts_present,
    // [132:100] escr_value, [133] escr_present, [136:134] error_code, rest zero
    output logic [pes_hp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [pes_hp_pkg::M_TUSER_W-1:0]   m_tuser,   // [2:0] byte_kind
    output logic                               m_tlast,   // packet_end
    // configuration: check_markers
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data
);
    import pes_hp_pkg::*;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [15:0]         idx_reg, idx_next;
    logic [7:0]          sid_reg, sid_next;
    logic [15:0]         len_reg, len_next;
    logic [2:0]          flags_reg, flags_next;    // escr, dts, pts present
    logic [7:0]          hdl_reg, hdl_next;        // header data length
    logic [STAMP_W-1:0]  pts_reg, pts_next;
    logic [STAMP_W-1:0]  dts_reg, dts_next;
    logic [STAMP_W-1:0]  escr_reg, escr_next;
    logic [2:0]          err_reg, err_next;
    logic                check_markers_reg;

    // result register
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    kind_t                  m_kind_reg, kind_next;
    logic                   m_tlast_reg, end_next;

    logic s_accept;
    logic [7:0] byte_in;
    logic       pkt_start;

    assign byte_in   = s_tdata[7:0];
    assign pkt_start = s_tuser[0];

    // take a new byte whenever the result slot is free or being emptied
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_tlast_reg;

    // one parse step
    always_comb begin
        phase_t             ph;
        logic [15:0]        idx;
        logic               post;
        logic               bad;
        logic [15:0]        cnt;
        logic [15:0]        off;
        logic [3:0]         pts_end;
        logic [3:0]         dts_end;
        logic [4:0]         need;
        logic [7:0]         want;

        // a packet start drops whatever was in progress
        ph          = pkt_start ? PH_PREFIX : phase_reg;
        idx         = pkt_start ? 16'd0 : idx_reg;
        sid_next    = pkt_start ? 8'd0 : sid_reg;
        len_next    = pkt_start ? 16'd0 : len_reg;
        flags_next  = pkt_start ? 3'd0 : flags_reg;
        hdl_next    = pkt_start ? 8'd0 : hdl_reg;
        pts_next    = pkt_start ? '0 : pts_reg;
        dts_next    = pkt_start ? '0 : dts_reg;
        escr_next   = pkt_start ? '0 : escr_reg;
        err_next    = pkt_start ? ERR_NONE : err_reg;

        post = ph inside {PH_HEADER, PH_PAYLOAD, PH_PADDING, PH_ERROR};

        phase_next = ph;
        idx_next   = idx;
        kind_next  = KIND_IDLE;
        end_next   = 1'b0;
        bad        = 1'b0;
        cnt        = 16'd0;
        off        = idx - 16'd3;
        want       = 8'd0;

        // optional field layout from the flags seen so far
        pts_end = flags_next[0] ? STAMP_BYTES : 4'd0;
        dts_end = pts_end + (flags_next[1] ? STAMP_BYTES : 4'd0);
        need    = {1'b0, dts_end} + (flags_next[2] ? {1'b0, ESCR_BYTES} : 5'd0);

        case (ph)
            PH_PREFIX: begin
                kind_next = KIND_HEADER;
                if (idx < 16'd3) begin
                    // start code 00 00 01
                    want = (idx == 16'd2) ? 8'h01 : 8'h00;
                    if (byte_in != want) begin
                        idx_next   = 16'd0;
                        len_next   = 16'd0;
                        err_next   = ERR_START_CODE;
                        phase_next = PH_ERROR;
                        kind_next  = KIND_ERROR;
                    end else begin
                        idx_next = idx + 16'd1;
                    end
                end else if (idx == 16'd3) begin
                    sid_next = byte_in;
                    idx_next = 16'd4;
                end else if (idx == 16'd4) begin
                    len_next = {byte_in, 8'd0};
                    idx_next = 16'd5;
                end else begin
                    // length low byte; counting restarts after it
                    len_next = {len_next[15:8], byte_in};
                    idx_next = 16'd0;
                    if (has_header(sid_next)) begin
                        phase_next = PH_HEADER;
                    end else begin
                        phase_next = (sid_next == SID_PADDING) ? PH_PADDING : PH_PAYLOAD;
                        kind_next  = KIND_HDR_END;
                    end
                end
            end
            PH_HEADER: begin
                kind_next = KIND_HEADER;
                if (idx == 16'd0) begin
                    if (check_markers_reg && byte_in[7:6] != MARKER_BITS) begin
                        bad      = 1'b1;
                        err_next = ERR_MARKER;
                    end
                end else if (idx == 16'd1) begin
                    // a pts/dts flag pair of 01 means no stamps
                    flags_next = {byte_in[5], byte_in[7:6] == 2'b11, byte_in[7]};
                end else if (idx == 16'd2) begin
                    hdl_next = byte_in;
                    if (byte_in < {3'd0, need}) begin
                        bad      = 1'b1;
                        err_next = ERR_HDR_SHORT;
                    end else if (byte_in == 8'd0) begin
                        phase_next = PH_PAYLOAD;
                        kind_next  = KIND_HDR_END;
                    end
                end else begin
                    if (off < {12'd0, pts_end}) begin
                        if (off == 16'd0 && check_markers_reg &&
                            byte_in[7:4] != (flags_next[1] ? PFX_PTS_WITH_DTS
                                                            : PFX_PTS_ONLY)) begin
                            bad      = 1'b1;
                            err_next = ERR_PTS_PREFIX;
                        end else begin
                            pts_next = stamp_update(pts_next, off[2:0], byte_in);
                        end
                    end else if (off < {12'd0, dts_end}) begin
                        if (off == {12'd0, pts_end} && check_markers_reg &&
                            byte_in[7:4] != PFX_DTS) begin
                            bad      = 1'b1;
                            err_next = ERR_DTS_PREFIX;
                        end else begin
                            dts_next = stamp_update(dts_next, off[2:0] - pts_end[2:0],
                                                    byte_in);
                        end
                    end else if (off < {11'd0, need}) begin
                        escr_next = escr_update(escr_next, off[2:0] - dts_end[2:0], byte_in);
                    end
                    // last byte of the stated header length
                    if (!bad && idx == 16'd2 + {8'd0, hdl_next}) begin
                        phase_next = PH_PAYLOAD;
                        kind_next  = KIND_HDR_END;
                    end
                end
                if (bad) begin
                    phase_next = PH_ERROR;
                    kind_next  = KIND_ERROR;
                end
            end
            PH_PAYLOAD: kind_next = KIND_PAYLOAD;
            PH_PADDING: kind_next = KIND_PADDING;
            PH_ERROR:   kind_next = KIND_ERROR;
            default:    kind_next = KIND_IDLE;
        endcase

        // count bytes after the length field, saturating for unbounded packets
        if (post) begin
            cnt      = (idx == 16'hFFFF) ? idx : idx + 16'd1;
            idx_next = cnt;
            if (len_next != 16'd0 && cnt == len_next) begin
                end_next = 1'b1;
                // packet ran out before the header did
                if (phase_next == PH_HEADER) begin
                    err_next  = ERR_HDR_SHORT;
                    kind_next = KIND_ERROR;
                end
                phase_next = PH_IDLE;
            end
        end

        m_tdata_next = {7'd0, err_next, flags_next[2], escr_next, flags_next[1], dts_next,
                        flags_next[0], pts_next, len_next, sid_next, byte_in};
    end

    // parser state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            idx_reg           <= 16'd0;
            sid_reg           <= 8'd0;
            len_reg           <= 16'd0;
            flags_reg         <= 3'd0;
            hdl_reg           <= 8'd0;
            pts_reg           <= '0;
            dts_reg           <= '0;
            escr_reg          <= '0;
            err_reg           <= ERR_NONE;
            check_markers_reg <= 1'b1;
        end else begin
            if (s_accept) begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                sid_reg   <= sid_next;
                len_reg   <= len_next;
                flags_reg <= flags_next;
                hdl_reg   <= hdl_next;
                pts_reg   <= pts_next;
                dts_reg   <= dts_next;
                escr_reg  <= escr_next;
                err_reg   <= err_next;
            end
            if (cfg_valid && cfg_ready) begin
                check_markers_reg <= cfg_data;
            end
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
            m_kind_reg  <= kind_next;
            m_tlast_reg <= end_next;
        end
    end

`ifndef SYNTHESIS
    // reset leaves the parser idle with no result pending
    assert property (@(posedge aclk) !aresetn |=> phase_reg == PH_IDLE && !m_tvalid_reg)
        else $error("parser not idle after reset");

    // a packet start always leaves the parser inside a packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && pkt_start |=> phase_reg == PH_PREFIX || phase_reg == PH_ERROR)
        else $error("packet start did not open a packet");

    // packet end never falls on an idle or plain header byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tlast_reg |-> m_kind_reg != KIND_IDLE && m_kind_reg != KIND_HEADER)
        else $error("packet end on idle or header byte");

    // every error byte carries a nonzero error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_kind_reg == KIND_ERROR |-> m_tdata_reg[136:134] != ERR_NONE)
        else $error("error byte without error code");

    // a clean header end has no error recorded
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_kind_reg == KIND_HDR_END |-> m_tdata_reg[136:134] == ERR_NONE)
        else $error("header end with error code set");
`endif

endmodule

@@ dv/pes_hp_checker.sv @@
`timescale 1ns / 1ps
// checker for the pes header parser: byte label prediction and result compare
module pes_hp_checker
    import pes_hp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [M_TUSER_W-1:0]   m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    localparam logic [7:0] START_TAIL = 8'h01;
    localparam int         PAD_LO     = 137;

    typedef struct {
        kind_t              kind;
        logic [7:0]         data;
        logic               last;
        logic [7:0]         sid;
        logic [15:0]        len;
        logic [STAMP_W-1:0] pts;
        logic               pts_on;
        logic [STAMP_W-1:0] dts;
        logic               dts_on;
        logic [STAMP_W-1:0] escr;
        logic               escr_on;
        logic [2:0]         err;
    } byte_label_t;

    byte_label_t        pending_labels[$];
    int                 errs;

    // parser copy
    phase_t             parse_ph;
    logic [15:0]        pos;
    logic [7:0]         sid_q;
    logic [15:0]        len_q;
    logic [2:0]         flags;
    logic [7:0]         hdr_len;
    logic [STAMP_W-1:0] pts_q;
    logic [STAMP_W-1:0] dts_q;
    logic [STAMP_W-1:0] escr_q;
    logic [2:0]         err_q;
    logic               chk;

    task automatic clear_packet();
        pos     = '0;
        sid_q   = '0;
        len_q   = '0;
        flags   = '0;
        hdr_len = '0;
        pts_q   = '0;
        dts_q   = '0;
        escr_q  = '0;
        err_q   = ERR_NONE;
    endtask

    function automatic kind_t abort_packet(input logic [2:0] code);
        err_q    = code;
        parse_ph = PH_ERROR;
        return KIND_ERROR;
    endfunction

    // pts and dts share one 5-byte layout
    function automatic logic [STAMP_W-1:0] stamp_merge(
        input logic [STAMP_W-1:0] old,
        input int                 j,
        input logic [7:0]         b
    );
        logic [STAMP_W-1:0] wide;
        wide = {25'd0, b};
        case (j)
            0:       return {b[3:1], 30'd0};
            1:       return old | (wide << 22);
            2:       return old | ((wide >> 1) << 15);
            3:       return old | (wide << 7);
            default: return old | (wide >> 1);
        endcase
    endfunction

    task automatic label_byte(input logic [7:0] b, input logic first, output byte_label_t r);
        kind_t              kind;
        logic               done;
        logic               counted;
        logic               bare;
        logic               has_dts;
        int                 pts_end;
        int                 dts_end;
        int                 need;
        int                 off;
        logic [STAMP_W-1:0] wide;
        kind = KIND_IDLE;
        done = 1'b0;
        wide = {25'd0, b};
        if (first) begin
            clear_packet();
            parse_ph = PH_PREFIX;
        end
        counted = parse_ph inside {PH_HEADER, PH_PAYLOAD, PH_PADDING, PH_ERROR};
        case (parse_ph)
            PH_PREFIX: begin
                kind = KIND_HEADER;
                if (pos < 16'd3) begin
                    if (b != ((pos == 16'd2) ? START_TAIL : 8'h00)) begin
                        pos   = '0;
                        len_q = '0;
                        kind  = abort_packet(ERR_START_CODE);
                    end else begin
                        pos = pos + 16'd1;
                    end
                end else if (pos == 16'd3) begin
                    sid_q = b;
                    pos   = 16'd4;
                end else if (pos == 16'd4) begin
                    len_q = {b, 8'h00};
                    pos   = 16'd5;
                end else begin
                    len_q = len_q | {8'h00, b};
                    pos   = '0;
                    case (sid_q)
                        8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: bare = 1'b1;
                        default: bare = 1'b0;
                    endcase
                    if (!bare) begin
                        parse_ph = PH_HEADER;
                    end else begin
                        parse_ph = (sid_q == SID_PADDING) ? PH_PADDING : PH_PAYLOAD;
                        kind     = KIND_HDR_END;
                    end
                end
            end
            PH_HEADER: begin
                has_dts = flags[1];
                pts_end = flags[0] ? 5 : 0;
                dts_end = pts_end + (has_dts ? 5 : 0);
                need    = dts_end + (flags[2] ? 6 : 0);
                kind    = KIND_HEADER;
                if (pos == 16'd0) begin
                    if (chk && b[7:6] != MARKER_BITS) kind = abort_packet(ERR_MARKER);
                end else if (pos == 16'd1) begin
                    flags = {b[5], b[7:6] == 2'b11, b[7]};
                end else if (pos == 16'd2) begin
                    hdr_len = b;
                    if (int'(b) < need) begin
                        kind = abort_packet(ERR_HDR_SHORT);
                    end else if (b == 8'd0) begin
                        parse_ph = PH_PAYLOAD;
                        kind     = KIND_HDR_END;
                    end
                end else begin
                    off = int'(pos) - 3;
                    if (off < pts_end) begin
                        if (off == 0 && chk &&
                            b[7:4] != (has_dts ? PFX_PTS_WITH_DTS : PFX_PTS_ONLY))
                            kind = abort_packet(ERR_PTS_PREFIX);
                        else
                            pts_q = stamp_merge(pts_q, off, b);
                    end else if (off < dts_end) begin
                        if (off == pts_end && chk && b[7:4] != PFX_DTS)
                            kind = abort_packet(ERR_DTS_PREFIX);
                        else
                            dts_q = stamp_merge(dts_q, off - pts_end, b);
                    end else if (off < need) begin
                        case (off - dts_end)
                            0: escr_q = {b[5:3], b[1:0], 28'd0};
                            1: escr_q = escr_q | (wide << 20);
                            2: escr_q = escr_q | (33'(b[7:3]) << 15) | (33'(b[1:0]) << 13);
                            3: escr_q = escr_q | (wide << 5);
                            4: escr_q = escr_q | 33'(b[7:3]);
                            default: ;
                        endcase
                    end
                    if (kind != KIND_ERROR && int'(pos) == int'(hdr_len) + 2) begin
                        parse_ph = PH_PAYLOAD;
                        kind     = KIND_HDR_END;
                    end
                end
            end
            PH_PAYLOAD: kind = KIND_PAYLOAD;
            PH_PADDING: kind = KIND_PADDING;
            PH_ERROR:   kind = KIND_ERROR;
            default:    kind = KIND_IDLE;
        endcase
        // byte count after the length field, saturating
        if (counted) begin
            if (pos != 16'hFFFF) pos = pos + 16'd1;
            if (len_q != 16'd0 && pos == len_q) begin
                done = 1'b1;
                if (parse_ph == PH_HEADER) begin
                    err_q = ERR_HDR_SHORT;
                    kind  = KIND_ERROR;
                end
                parse_ph = PH_IDLE;
            end
        end
        r.kind    = kind;
        r.data    = b;
        r.last    = done;
        r.sid     = sid_q;
        r.len     = len_q;
        r.pts     = pts_q;
        r.pts_on  = flags[0];
        r.dts     = dts_q;
        r.dts_on  = flags[1];
        r.escr    = escr_q;
        r.escr_on = flags[2];
        r.err     = err_q;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin : watch
        byte_label_t want;
        if (!aresetn) begin
            clear_packet();
            parse_ph = PH_IDLE;
            chk      = 1'b1;
            pending_labels.delete();
            errs     = 0;
        end else begin
            if (cfg_valid && cfg_ready) chk = cfg_data;
            if (s_tvalid && s_tready) begin
                label_byte(s_tdata[7:0], s_tuser[0], want);
                pending_labels.insert(pending_labels.size(), want);
            end
            if (m_tvalid && m_tready) begin
                if (pending_labels.size() == 0) begin
                    $display("%0t ns: result expected none actual %0h", $time, m_tdata);
                    errs++;
                end else begin
                    want = pending_labels.pop_front();
                    compare_field("byte_kind",    want.kind,    m_tuser[2:0]);
                    compare_field("byte_out",     want.data,    m_tdata[7:0]);
                    compare_field("packet_end",   want.last,    m_tlast);
                    compare_field("stream_ident", want.sid,     m_tdata[15:8]);
                    compare_field("length_field", want.len,     m_tdata[31:16]);
                    compare_field("pts_value",    want.pts,     m_tdata[64:32]);
                    compare_field("pts_present",  want.pts_on,  m_tdata[65]);
                    compare_field("dts_value",    want.dts,     m_tdata[98:66]);
                    compare_field("dts_present",  want.dts_on,  m_tdata[99]);
                    compare_field("escr_value",   want.escr,    m_tdata[132:100]);
                    compare_field("escr_present", want.escr_on, m_tdata[133]);
                    compare_field("error_code",   want.err,     m_tdata[136:134]);
                    compare_field("tdata_pad",    '0,           m_tdata[M_TDATA_W-1:PAD_LO]);
                end
            end
        end
        mismatches  <= errs;
        outstanding <= pending_labels.size();
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// top of the pes header parser testbench: clock, reset, stimulus and verdict
module testbench;
    import pes_hp_pkg::*;

    localparam int         RESET_CYCLES = 10;
    localparam int         HOLD_CYCLES  = 300;     // long sink hold-off
    localparam int         CYCLE_LIMIT  = 500000;  // far above the slowest legal run
    localparam logic [7:0] START_TAIL   = 8'h01;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [7:0] data_byte
    logic [S_TUSER_W-1:0] s_tuser;   // [0] packet_start
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] byte_out, [15:8] stream_ident, [31:16] length_field,
    // [64:32] pts_value, [65] pts_present, [98:66] dts_value, [99] dts_present,
    // [132:100] escr_value, [133] escr_present, [136:134] error_code
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;   // [2:0] byte_kind
    logic                 m_tlast;   // packet_end
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    int                   mismatches;
    int                   outstanding;
    int                   cycle_count = 0;

    // stimulus control shared with the sink process
    bit                   calm      = 1'b0;  // no idling on either side
    bit                   long_hold = 1'b0;  // ask the sink for one long hold-off
    bit                   hold_done = 1'b0;

    logic [7:0]           frame_q[$];        // one packet being sent
    logic [7:0]           bare_ids[0:7];     // ids with no optional header

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    pes_header_parser_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pes_hp_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // sink side: random stall bursts, one long hold-off on request
    initial begin : sink
        m_tready = 1'b0;
        forever begin
            if (long_hold && !hold_done) begin
                // hold-off counted here while the sender keeps offering bytes,
                // so the result register fills and s_tready drops
                m_tready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // one byte request, with an optional idle burst in front of it
    task automatic push_byte(input logic [7:0] b, input logic first);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // frame_q goes out with packet_start on its first byte
    task automatic send_frame();
        foreach (frame_q[i]) push_byte(frame_q[i], i == 0);
    endtask

    // drain every expected result before touching the register;
    // the first edge lets the count see the last request taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_markers(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed packets with random content, plus noise,
    // corrupted prefixes, short headers and truncated packets
    task automatic random_phase(input int budget, input bit stall_once);
        int         sent;
        int         pick;
        int         need;
        int         cut;
        int         i;
        logic [1:0] pd;
        logic       escr_on;
        logic [7:0] sid;
        logic [7:0] hl;
        logic [15:0] plen;
        logic [7:0] body_q[$];
        sent = 0;
        while (sent < budget) begin
            if (stall_once && sent > budget / 3) long_hold = 1'b1;
            pick = $urandom_range(0, 9);
            body_q.delete();
            if (pick == 0) begin
                // stray bytes, now and then with packet_start
                repeat ($urandom_range(1, 6)) begin
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0);
                    sent++;
                end
            end else begin
                if (pick == 1) begin
                    // id without optional header: straight to payload or padding
                    sid = bare_ids[$urandom_range(0, 7)];
                end else begin
                    case ($urandom_range(0, 7))
                        0:       sid = 8'hBD;
                        1:       sid = 8'($urandom);
                        default: sid = 8'($urandom_range(8'hC0, 8'hEF));
                    endcase
                    pd      = 2'($urandom);
                    escr_on = 1'($urandom);
                    need    = (pd[1] ? 5 : 0) + (pd == 2'b11 ? 5 : 0) + (escr_on ? 6 : 0);
                    hl      = 8'(need + $urandom_range(0, 3));
                    if ($urandom_range(0, 9) == 0) hl = 8'($urandom_range(0, need));
                    body_q.insert(body_q.size(), {MARKER_BITS, 6'($urandom)});
                    body_q.insert(body_q.size(), {pd, escr_on, 5'($urandom)});
                    body_q.insert(body_q.size(), hl);
                    if (pd[1]) begin
                        body_q.insert(body_q.size(),
                                      {(pd[0] ? PFX_PTS_WITH_DTS : PFX_PTS_ONLY),
                                       4'($urandom)});
                        repeat (4) body_q.insert(body_q.size(), 8'($urandom));
                    end
                    if (pd == 2'b11) begin
                        body_q.insert(body_q.size(), {PFX_DTS, 4'($urandom)});
                        repeat (4) body_q.insert(body_q.size(), 8'($urandom));
                    end
                    if (escr_on) repeat (6) body_q.insert(body_q.size(), 8'($urandom));
                    // stuffing and other optional fields up to the header length
                    while (body_q.size() < int'(hl) + 3)
                        body_q.insert(body_q.size(), 8'($urandom));
                end
                repeat ($urandom_range(0, 10)) body_q.insert(body_q.size(), 8'($urandom));
                case ($urandom_range(0, 9))
                    6:       plen = 16'd0;                                   // unbounded
                    7:       plen = 16'($urandom_range(1, body_q.size()));  // ends early
                    8:       plen = 16'($urandom);
                    default: plen = 16'(body_q.size());
                endcase
                frame_q.delete();
                frame_q.insert(frame_q.size(), 8'h00);
                frame_q.insert(frame_q.size(), 8'h00);
                frame_q.insert(frame_q.size(), START_TAIL);
                frame_q.insert(frame_q.size(), sid);
                frame_q.insert(frame_q.size(), plen[15:8]);
                frame_q.insert(frame_q.size(), plen[7:0]);
                foreach (body_q[k]) frame_q.insert(frame_q.size(), body_q[k]);
                // flip one bit among the first 12 bytes: start code, id, length and the bytes after them
                if ($urandom_range(0, 7) == 0) begin
                    cut = (frame_q.size() < 12) ? frame_q.size() : 12;
                    i   = $urandom_range(0, cut - 1);
                    frame_q[i] = frame_q[i] ^ (8'h01 << $urandom_range(0, 7));
                end
                // cut short: the next packet_start aborts it
                if ($urandom_range(0, 9) == 0) begin
                    cut = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > cut) void'(frame_q.pop_back());
                end
                send_frame();
                sent += frame_q.size();
            end
        end
    endtask

    initial begin : stimulus
        bare_ids = '{8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF};
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        write_markers(1'b1);

        // bytes before any packet
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // wrong second start code byte, then error bytes
        frame_q = '{8'h00, 8'h05, 8'h00};
        send_frame();
        // padding stream, one byte long
        frame_q = '{8'h00, 8'h00, START_TAIL, SID_PADDING, 8'h00, 8'h01, 8'hFF};
        send_frame();
        // pts flagged but header data length zero, unbounded length
        frame_q = '{8'h00, 8'h00, START_TAIL, 8'hC0, 8'h00, 8'h00, 8'h80, 8'h80, 8'h00};
        send_frame();
        // new packet aborts the one above; ends on an empty header
        frame_q = '{8'h00, 8'h00, START_TAIL, 8'hE0, 8'h00, 8'h03, 8'h80, 8'h00, 8'h00};
        send_frame();
        wait_idle();

        random_phase(400, 1'b1);
        wait_idle();

        // marker and prefix checks off
        write_markers(1'b0);
        random_phase(250, 1'b0);
        wait_idle();

        // checks back on, last stretch with no idling at all
        write_markers(1'b1);
        calm = 1'b1;
        random_phase(250, 1'b0);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ pes_header_parser_core.f @@
rtl/pes_hp_pkg.sv
rtl/pes_header_parser_core.sv
dv/pes_hp_checker.sv
dv/testbench.sv
